[design/buddy_page_allocator_unit_defines.svh]
// Assertion helpers used by the checker file.
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/bpa_pkg.sv]
package bpa_pkg;

    localparam int PAGE_W        = 20;
    localparam int REQ_W         = 11;
    localparam int STATUS_W      = 3;
    localparam int ORDER_W       = 4;
    localparam int ENTRY_W       = 6;
    localparam int MIN_REGION    = 128;
    localparam int NUM_ORDERS_DEF = 10;
    localparam int MAX_PAGES_DEF  = 1024;

    localparam logic [0:0] CFG_BASE_PAGE    = 1'b0;
    localparam logic [0:0] CFG_REGION_PAGES = 1'b1;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_MEM    = 3'd1,
        ST_BAD_SIZE  = 3'd2,
        ST_NOT_ALLOC = 3'd3,
        ST_NOT_INIT  = 3'd4,
        ST_BAD_CFG   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DECIDE,
        OP_CLEAR,
        OP_CARVE,
        OP_SCAN_RD,
        OP_SCAN_CHK,
        OP_SPLIT,
        OP_ALLOC_WR,
        OP_FREE_RD,
        OP_FREE_CHK,
        OP_MERGE_RD,
        OP_MERGE_CHK,
        OP_FREE_WR,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic go;
        logic clear_last;
        logic carve_last;
        logic scan_end;
        logic hit;
        logic need_split;
        logic split_more;
        logic free_ok;
        logic merge_go;
        logic out_busy;
    } t_dp_stat;

endpackage

[design/bpa_req_if.sv]
interface bpa_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic [bpa_pkg::REQ_W-1:0]  request_pages;
    logic [bpa_pkg::PAGE_W-1:0] release_page;

    modport source (output valid, command, request_pages, release_page, input ready);
    modport sink   (input valid, command, request_pages, release_page, output ready);
endinterface

[design/bpa_res_if.sv]
interface bpa_res_if;
    logic                        valid;
    logic                        ready;
    logic [bpa_pkg::STATUS_W-1:0] status;
    logic [bpa_pkg::PAGE_W-1:0]   block_page;
    logic                        region_full;

    modport source (output valid, status, block_page, region_full, input ready);
    modport sink   (input valid, status, block_page, region_full, output ready);
endinterface

[design/bpa_ram.sv]
module bpa_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/bpa_ctrl.sv]
module bpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bpa_pkg::t_dp_stat  i_stat,
    output bpa_pkg::t_dp_cmd   o_ctl
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CLEAR, S_CARVE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT,
        S_ALLOC_WR, S_FREE_RD, S_FREE_CHK, S_MERGE_RD, S_MERGE_CHK, S_FREE_WR,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    t_op    op;

    always_comb begin
        n_state = r_state;
        op      = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                op = OP_DECIDE;
                if (!i_stat.go) begin
                    n_state = S_FINISH;
                end else begin
                    unique case (i_stat.cmd)
                        CMD_INIT:  n_state = S_CLEAR;
                        CMD_ALLOC: n_state = S_SCAN_RD;
                        CMD_FREE:  n_state = S_FREE_RD;
                        default:   n_state = S_FINISH;
                    endcase
                end
            end
            S_CLEAR: begin
                op = OP_CLEAR;
                if (i_stat.clear_last) n_state = S_CARVE;
            end
            S_CARVE: begin
                op = OP_CARVE;
                if (i_stat.carve_last) n_state = S_FINISH;
            end
            S_SCAN_RD: begin
                op      = OP_SCAN_RD;
                n_state = i_stat.scan_end ? S_FINISH : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                op = OP_SCAN_CHK;
                if (!i_stat.hit)            n_state = S_SCAN_RD;
                else if (i_stat.need_split) n_state = S_SPLIT;
                else                        n_state = S_ALLOC_WR;
            end
            S_SPLIT: begin
                op = OP_SPLIT;
                if (!i_stat.split_more) n_state = S_ALLOC_WR;
            end
            S_ALLOC_WR: begin
                op      = OP_ALLOC_WR;
                n_state = S_FINISH;
            end
            S_FREE_RD: begin
                op      = OP_FREE_RD;
                n_state = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                op      = OP_FREE_CHK;
                n_state = i_stat.free_ok ? S_MERGE_RD : S_FINISH;
            end
            S_MERGE_RD: begin
                op      = OP_MERGE_RD;
                n_state = i_stat.merge_go ? S_MERGE_CHK : S_FREE_WR;
            end
            S_MERGE_CHK: begin
                op      = OP_MERGE_CHK;
                n_state = i_stat.hit ? S_MERGE_RD : S_FREE_WR;
            end
            S_FREE_WR: begin
                op      = OP_FREE_WR;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    op      = OP_PUSH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_ctl.op   = op;
endmodule

[design/bpa_datapath.sv]
module bpa_datapath #(
    parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF,
    parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [bpa_pkg::PAGE_W-1:0]   i_cfg_data,
    input  logic [1:0]                  i_command,
    input  logic [bpa_pkg::REQ_W-1:0]    i_request_pages,
    input  logic [bpa_pkg::PAGE_W-1:0]   i_release_page,
    input  bpa_pkg::t_dp_cmd            i_ctl,
    output bpa_pkg::t_dp_stat           o_stat,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [bpa_pkg::STATUS_W-1:0] o_status,
    output logic [bpa_pkg::PAGE_W-1:0]   o_block_page,
    output logic                        o_region_full
);
    import bpa_pkg::*;

    localparam int PW  = $clog2(MAX_PAGES);
    localparam int XW  = (PW + 1 > NUM_ORDERS) ? PW + 1 : NUM_ORDERS;
    localparam int OW  = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
    localparam int TOP = NUM_ORDERS - 1;

    function automatic logic [4:0] flog2(input logic [31:0] v);
        logic [4:0] k;
        k = 5'd0;
        for (int b = 1; b < 32; b++) begin
            if (v[b]) k = 5'(b);
        end
        return k;
    endfunction

    logic [PAGE_W-1:0]  r_base;
    logic [REQ_W-1:0]   r_pages;
    logic [PAGE_W-1:0]  r_act_base;
    logic [XW-1:0]      r_act_pages;
    logic               r_ready;
    logic [XW-1:0]      r_cnt [NUM_ORDERS];
    t_cmd               r_cmd;
    logic [REQ_W-1:0]   r_req;
    logic [PAGE_W-1:0]  r_rel;
    logic [XW-1:0]      r_ptr;
    logic [XW-1:0]      r_rem;
    logic [ORDER_W-1:0] r_ord;
    logic [ORDER_W-1:0] r_need;
    t_status            r_status;
    logic [PAGE_W-1:0]  r_page;
    logic               r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [PAGE_W-1:0]  r_o_page;
    logic               r_o_full;

    logic               mem_we;
    logic [PW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [PW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    bpa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PAGES)) u_page_info (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic               rd_head, rd_alloc;
    logic [ORDER_W-1:0] rd_ord;
    assign rd_head  = mem_rdata[ENTRY_W-1];
    assign rd_alloc = mem_rdata[ENTRY_W-2];
    assign rd_ord   = mem_rdata[ORDER_W-1:0];

    logic [4:0]         big5, carve5, need5;
    logic [ORDER_W-1:0] big, carve_k, need, fit_ord, ord_dn;
    logic               init_bad, size_bad, fit_found, full_now;
    logic [PAGE_W-1:0]  rel_off;
    logic [XW-1:0]      blk, bud, half;
    logic               hit;
    t_status            dec_status;
    logic               dec_go;

    always_comb begin
        big5    = flog2(32'(r_pages));
        big     = (big5 > 5'(TOP)) ? ORDER_W'(TOP) : big5[ORDER_W-1:0];
        carve5  = flog2(32'(r_rem));
        carve_k = (carve5 > 5'(TOP)) ? ORDER_W'(TOP) : carve5[ORDER_W-1:0];
        need5   = (r_req <= REQ_W'(1)) ? 5'd0 : flog2(32'(r_req - REQ_W'(1))) + 5'd1;
        need    = need5[ORDER_W-1:0];
        ord_dn  = r_ord - ORDER_W'(1);

        init_bad = (32'(r_pages) < 32'(MIN_REGION)) || (32'(r_pages) > 32'(MAX_PAGES))
                || ((r_base & ((PAGE_W'(1) << big) - PAGE_W'(1))) != '0)
                || ((21'(r_base) + 21'(r_pages)) > (21'd1 << PAGE_W));
        size_bad = (r_req == '0) || (32'(r_req) > (32'd1 << TOP));

        full_now  = 1'b1;
        fit_found = 1'b0;
        fit_ord   = '0;
        for (int j = NUM_ORDERS - 1; j >= 0; j--) begin
            if (r_cnt[j] != '0) begin
                full_now = 1'b0;
                if (ORDER_W'(j) >= need) begin
                    fit_found = 1'b1;
                    fit_ord   = ORDER_W'(j);
                end
            end
        end

        rel_off = r_rel - r_act_base;
        blk     = XW'(1) << carve_k;
        bud     = r_ptr ^ (XW'(1) << r_ord);
        half    = r_ptr + (XW'(1) << ord_dn);
        hit     = rd_head && !rd_alloc && (rd_ord == r_ord);

        dec_status = ST_OK;
        dec_go     = 1'b0;
        unique case (r_cmd)
            CMD_INIT: begin
                dec_status = init_bad ? ST_BAD_CFG : ST_OK;
                dec_go     = !init_bad;
            end
            CMD_ALLOC: begin
                priority if (!r_ready) dec_status = ST_NOT_INIT;
                else if (size_bad)     dec_status = ST_BAD_SIZE;
                else if (full_now)     dec_status = ST_NO_MEM;
                else if (!fit_found)   dec_status = ST_NO_MEM;
                else                   dec_go     = 1'b1;
            end
            CMD_FREE: begin
                priority if (!r_ready)                      dec_status = ST_NOT_INIT;
                else if (r_rel < r_act_base)                dec_status = ST_NOT_ALLOC;
                else if (32'(rel_off) >= 32'(r_act_pages))  dec_status = ST_NOT_ALLOC;
                else                                        dec_go     = 1'b1;
            end
            default: dec_status = ST_OK;
        endcase
    end

    // page table port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr[PW-1:0];
        mem_wdata = '0;
        mem_raddr = r_ptr[PW-1:0];
        unique case (i_ctl.op)
            OP_CLEAR: mem_we = 1'b1;
            OP_CARVE: begin
                mem_we    = 1'b1;
                mem_wdata = {2'b10, carve_k};
            end
            OP_SPLIT: begin
                mem_we    = (32'(half) < 32'(MAX_PAGES));
                mem_waddr = half[PW-1:0];
                mem_wdata = {2'b10, ord_dn};
            end
            OP_ALLOC_WR: begin
                mem_we    = 1'b1;
                mem_wdata = {2'b11, r_need};
            end
            OP_FREE_CHK: mem_we = rd_head && rd_alloc;
            OP_MERGE_RD: mem_raddr = bud[PW-1:0];
            OP_MERGE_CHK: begin
                mem_we    = hit;
                mem_waddr = bud[PW-1:0];
            end
            OP_FREE_WR: begin
                mem_we    = 1'b1;
                mem_wdata = {2'b10, r_ord};
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_pages   <= REQ_W'(1024);
            r_ready   <= 1'b0;
            r_o_valid <= 1'b0;
            for (int j = 0; j < NUM_ORDERS; j++) r_cnt[j] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BASE_PAGE) r_base  <= i_cfg_data;
                else                            r_pages <= i_cfg_data[REQ_W-1:0];
            end
            if (i_ctl.op == OP_PUSH)  r_o_valid <= 1'b1;
            else if (i_out_ready)     r_o_valid <= 1'b0;

            unique case (i_ctl.op)
                OP_DECIDE: begin
                    if (r_cmd == CMD_INIT && dec_go) begin
                        r_ready <= 1'b1;
                        for (int j = 0; j < NUM_ORDERS; j++) r_cnt[j] <= '0;
                    end
                end
                OP_CARVE:     r_cnt[carve_k[OW-1:0]] <= r_cnt[carve_k[OW-1:0]] + XW'(1);
                OP_SCAN_CHK:  if (hit) r_cnt[r_ord[OW-1:0]] <= r_cnt[r_ord[OW-1:0]] - XW'(1);
                OP_SPLIT: begin
                    if (32'(half) < 32'(MAX_PAGES))
                        r_cnt[ord_dn[OW-1:0]] <= r_cnt[ord_dn[OW-1:0]] + XW'(1);
                end
                OP_MERGE_CHK: if (hit) r_cnt[r_ord[OW-1:0]] <= r_cnt[r_ord[OW-1:0]] - XW'(1);
                OP_FREE_WR:   r_cnt[r_ord[OW-1:0]] <= r_cnt[r_ord[OW-1:0]] + XW'(1);
                default: ;
            endcase
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_LOAD: begin
                r_cmd <= t_cmd'(i_command);
                r_req <= i_request_pages;
                r_rel <= i_release_page;
            end
            OP_DECIDE: begin
                r_status <= dec_status;
                r_page   <= '0;
                unique case (r_cmd)
                    CMD_INIT: begin
                        r_ptr <= '0;
                        r_rem <= XW'(r_pages);
                        if (dec_go) begin
                            r_act_base  <= r_base;
                            r_act_pages <= XW'(r_pages);
                        end
                    end
                    CMD_ALLOC: begin
                        r_ptr  <= '0;
                        r_ord  <= fit_ord;
                        r_need <= need;
                    end
                    CMD_FREE: r_ptr <= XW'(rel_off);
                    default: ;
                endcase
            end
            OP_CLEAR: r_ptr <= (r_ptr == XW'(MAX_PAGES - 1)) ? '0 : r_ptr + XW'(1);
            OP_CARVE: begin
                r_ptr <= r_ptr + blk;
                r_rem <= r_rem - blk;
            end
            OP_SCAN_RD: if (32'(r_ptr) >= 32'(r_act_pages)) r_status <= ST_NO_MEM;
            OP_SCAN_CHK: begin
                if (!hit) r_ptr <= r_ptr + (rd_head ? (XW'(1) << rd_ord) : XW'(1));
            end
            OP_SPLIT:    r_ord  <= ord_dn;
            OP_ALLOC_WR: r_page <= r_act_base + PAGE_W'(r_ptr);
            OP_FREE_CHK: begin
                if (rd_head && rd_alloc) r_ord    <= rd_ord;
                else                     r_status <= ST_NOT_ALLOC;
            end
            OP_MERGE_CHK: begin
                if (hit) begin
                    r_ord <= r_ord + ORDER_W'(1);
                    if (bud < r_ptr) r_ptr <= bud;
                end
            end
            OP_PUSH: begin
                r_o_status <= r_status;
                r_o_page   <= r_page;
                r_o_full   <= full_now;
            end
            default: ;
        endcase
    end

    assign o_stat.cmd        = r_cmd;
    assign o_stat.go         = dec_go;
    assign o_stat.clear_last = (r_ptr == XW'(MAX_PAGES - 1));
    assign o_stat.carve_last = (r_rem == blk);
    assign o_stat.scan_end   = (32'(r_ptr) >= 32'(r_act_pages));
    assign o_stat.hit        = hit;
    assign o_stat.need_split = (r_ord > r_need);
    assign o_stat.split_more = (ord_dn > r_need);
    assign o_stat.free_ok    = rd_head && rd_alloc;
    assign o_stat.merge_go   = (32'(r_ord) < 32'(TOP)) && (32'(bud) < 32'(r_act_pages));
    assign o_stat.out_busy   = r_o_valid && !i_out_ready;

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_block_page  = r_o_page;
    assign o_region_full = r_o_full;
endmodule

[design/buddy_page_allocator_unit.sv]
// Channel   Dir  Payload                                       Handshake
// i_req     in   command, request_pages, release_page         valid/ready
// o_res     out  status, block_page, region_full              valid/ready
// i_cfg_*   in   base_page (idx 0), region_pages (idx 1)      write enable
//
// One command at a time; i_req.ready is high only while the controller idles.
// After the accepting edge every command passes a decode state, its walk, then a state
//   that hands the result over; errors found at decode have no walk. Init walk: a clearing
//   sweep of the whole page table, then one write per block carved. Alloc walk: read and
//   check per block head scanned (registered RAM read), a split step per split, a mark
//   write; free walk: read and check, a read and check per merge step, then a write, none
//   when the page is no allocated head. A stalled o_res holds the controller in its
//   handoff; the next item can be taken in the cycle after the result register loads.
// Reset (i_rst_n low, synchronous) clears counters and flags; table is rewritten by init.
module buddy_page_allocator_unit #(
    parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF,
    parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [bpa_pkg::PAGE_W-1:0] i_cfg_data,
    bpa_req_if.sink                   i_req,
    bpa_res_if.source                 o_res
);
    import bpa_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    // sequence each command through the datapath ops
    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // hold region state, free counts, page table and the result register
    bpa_datapath #(.NUM_ORDERS(NUM_ORDERS), .MAX_PAGES(MAX_PAGES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_req.command),
        .i_request_pages (i_req.request_pages),
        .i_release_page  (i_req.release_page),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_status        (o_res.status),
        .o_block_page    (o_res.block_page),
        .o_region_full   (o_res.region_full)
    );
endmodule

[design/bpa_checker.sv]
`include "buddy_page_allocator_unit_defines.svh"

module bpa_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_we,
    input logic                      i_cfg_idx,
    input logic [bpa_pkg::PAGE_W-1:0] i_cfg_data,
    bpa_req_if.sink                  i_req,
    bpa_res_if.source                o_res
);
    import bpa_pkg::*;

    `BPA_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.status) && $stable(o_res.block_page))
    `BPA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    `BPA_ASSERT_NOW(a_page_only_ok, i_clk, i_rst_n, o_res.valid && o_res.block_page != '0, o_res.status == ST_OK)
    `BPA_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_res.valid, o_res.status <= ST_BAD_CFG)
endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (.*);
